// File: sv/punctured_conv_encoder_k7_macros.svh
// ----------------------------------------------------------------------------
// punctured_conv_encoder_k7 assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef PUNCTURED_CONV_ENCODER_K7_MACROS_SVH
`define PUNCTURED_CONV_ENCODER_K7_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication under reset
`define PCE_ASSERT_IMP(lbl, clk, rstn, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (con)) \
    else $error("pce assertion failed");

// next-cycle implication under reset
`define PCE_ASSERT_NEXT(lbl, clk, rstn, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (con)) \
    else $error("pce assertion failed");

`else

`define PCE_ASSERT_IMP(lbl, clk, rstn, pre, con)
`define PCE_ASSERT_NEXT(lbl, clk, rstn, pre, con)

`endif

`endif

// File: sv/pce_pkg.sv
// ----------------------------------------------------------------------------
// pce_pkg
// shared types, rate codes and the k=7 encoder function
// ----------------------------------------------------------------------------
`default_nettype none

package pce_pkg;

  // generator taps over the 7-bit shift register
  localparam logic [6:0] TAPS_X = 7'h79;
  localparam logic [6:0] TAPS_Y = 7'h5B;

  // puncture rate codes
  localparam logic [2:0] RATE_1_2 = 3'd0;
  localparam logic [2:0] RATE_2_3 = 3'd1;
  localparam logic [2:0] RATE_3_4 = 3'd2;
  localparam logic [2:0] RATE_5_6 = 3'd3;
  localparam logic [2:0] RATE_7_8 = 3'd4;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // one queued byte: eight raw dibits (index 0 first) and its rate
  typedef struct packed {
    logic [7:0][1:0] dibits;
    logic [2:0]      rate;
  } entry_t;

  // encoder result for one byte
  typedef struct packed {
    logic [7:0][1:0] dibits;
    logic [6:0]      sr;
  } enc_t;

  // back-end status seen by the top level
  typedef struct packed {
    logic       busy;
    logic [2:0] pend_cnt;
  } back_status_t;

  // run one byte through the shift register, msb first
  function automatic enc_t encode_byte(logic [6:0] sr, logic [7:0] data);
    enc_t       r;
    logic [6:0] s;
    s = sr;
    r = '0;
    for (int b = 7; b >= 0; b--) begin
      s = {data[b], s[6:1]};
      r.dibits[7-b] = {^(s & TAPS_Y), ^(s & TAPS_X)};
    end
    r.sr = s;
    return r;
  endfunction

  // dibits collected per puncture group
  function automatic logic [2:0] group_size(logic [2:0] rate);
    logic [2:0] s;
    case (rate)
      RATE_2_3: s = 3'd4;
      RATE_3_4: s = 3'd3;
      RATE_5_6: s = 3'd5;
      RATE_7_8: s = 3'd7;
      default:  s = 3'd1;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: sv/punctured_conv_encoder_k7.sv
// path: at rate 1/2 a byte's first dibit passes the queue, the current-byte register and the result stage
// at punctured rates the walker must also fill the first group before any result shows
// throughput: one raw dibit per cycle through the back-end walker while it does not stall
// a finished group waits while the result stage still holds an earlier group
// reset: clears code_rate, shift register, group fill, queue and result stage
// ----------------------------------------------------------------------------
// punctured_conv_encoder_k7
// k=7 rate 1/2 convolutional encoder with dvb puncturing, queue interfaces
// ----------------------------------------------------------------------------
`default_nettype none

`include "punctured_conv_encoder_k7_macros.svh"

module punctured_conv_encoder_k7 #(
  parameter int QUEUE_DEPTH = pce_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_code_rate,
  input  wire logic       in_push,
  input  wire logic [7:0] in_data_byte,
  output logic            in_full,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [1:0]      out_dibit,
  output logic            out_last_of_run
);

  logic                  q_push, q_valid, q_pop;
  pce_pkg::entry_t       q_in, q_out;
  pce_pkg::back_status_t bstat;

  // front: configuration, shift register, encoding
  pce_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_code_rate (cfg_code_rate),
    .in_push       (in_push),
    .in_data_byte  (in_data_byte),
    .q_full        (in_full),
    .q_push        (q_push),
    .q_entry       (q_in)
  );

  // decoupling queue
  pce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (in_full),
    .valid      (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_out)
  );

  // back: puncturing and result stage
  pce_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_entry         (q_out),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_dibit       (out_dibit),
    .out_last_of_run (out_last_of_run),
    .status          (bstat)
  );

  // checks
  `PCE_ASSERT_IMP(a_pend_bound, clk, rst_n, 1'b1, bstat.pend_cnt <= 3'd4)
  `PCE_ASSERT_NEXT(a_accept_held, clk, rst_n, q_push, q_valid || bstat.busy)
  `PCE_ASSERT_NEXT(a_idle_quiet, clk, rst_n, out_empty && !bstat.busy && !q_valid, out_empty)
  `PCE_ASSERT_IMP(a_no_pop_idle, clk, rst_n, !bstat.busy, !q_pop || q_valid)

endmodule

`default_nettype wire

// File: sv/pce_front.sv
// ----------------------------------------------------------------------------
// pce_front
// accepts bytes, holds code_rate and the shift register, encodes a byte
// ----------------------------------------------------------------------------
`default_nettype none

module pce_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_code_rate,
  input  wire logic           in_push,
  input  wire logic [7:0]     in_data_byte,
  input  wire logic           q_full,
  output logic                q_push,
  output pce_pkg::entry_t     q_entry
);

  logic [2:0]    rate_r;
  logic [6:0]    sr_r;
  pce_pkg::enc_t enc;

  // encode against the current register contents
  assign enc    = pce_pkg::encode_byte(sr_r, in_data_byte);
  assign q_push = in_push && !q_full;

  // classify: unused rate codes act as 1/2
  always_comb begin
    q_entry.dibits = enc.dibits;
    if (rate_r > pce_pkg::RATE_7_8) begin
      q_entry.rate = pce_pkg::RATE_1_2;
    end else begin
      q_entry.rate = rate_r;
    end
  end

  // configuration and shift register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= pce_pkg::RATE_1_2;
      sr_r   <= '0;
    end else begin
      if (cfg_we) begin
        rate_r <= cfg_code_rate;
      end
      if (q_push) begin
        sr_r <= enc.sr;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/pce_queue.sv
// ----------------------------------------------------------------------------
// pce_queue
// small fifo of encoded bytes between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module pce_queue #(
  parameter int DEPTH = pce_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire pce_pkg::entry_t push_entry,
  output logic                 full,
  output logic                 valid,
  input  wire logic            pop,
  output pce_pkg::entry_t      pop_entry
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  pce_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign valid     = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && valid;
  assign pop_entry = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/pce_back.sv
// ----------------------------------------------------------------------------
// pce_back
// walks the dibits of a byte one per cycle while the result stage has room, punctures, drives the result port
// ----------------------------------------------------------------------------
`default_nettype none

module pce_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire pce_pkg::entry_t   q_entry,
  output logic                   q_pop,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic [1:0]             out_dibit,
  output logic                   out_last_of_run,
  output pce_pkg::back_status_t  status
);

  // current byte
  pce_pkg::entry_t cur_r;
  logic [2:0]      idx_r;
  logic            busy_r;

  // puncture group state
  logic [1:0] gb_r [7];
  logic [2:0] fill_r;

  // pending results of a finished group, oldest in entry 0
  logic [1:0] pend_r [4];
  logic [1:0] pend_nxt [4];
  logic [2:0] pend_cnt_r, pend_cnt_nxt;
  logic       pend_last_r, pend_last_nxt;

  logic [1:0] d;
  logic [2:0] size, fill0, fill1;
  logic [1:0] gbe [7];
  logic [1:0] res [4];
  logic [2:0] res_cnt;
  logic       punct, complete, group_last, pend_free, step, pop_ok;

  assign d     = cur_r.dibits[idx_r];
  assign size  = pce_pkg::group_size(cur_r.rate);
  assign punct = (cur_r.rate != pce_pkg::RATE_1_2);
  assign fill0 = (fill_r >= size) ? 3'd0 : fill_r;
  assign fill1 = fill0 + 3'd1;

  // group buffer as it stands with the current dibit written in
  always_comb begin
    for (int k = 0; k < 7; k++) begin
      gbe[k] = (3'(k) == fill0) ? d : gb_r[k];
    end
  end

  assign complete   = !punct || (fill1 == size);
  // no further group can finish inside this byte
  assign group_last = ({1'b0, idx_r} + {1'b0, size}) > 4'd7;

  // puncture patterns, bit 0 is I and bit 1 is Q
  always_comb begin
    res[0]  = gbe[0];
    res[1]  = {gbe[2][0], gbe[1][1]};
    res[2]  = {gbe[3][1], gbe[2][1]};
    res[3]  = {gbe[6][0], gbe[5][1]};
    res_cnt = 3'd1;
    case (cur_r.rate)
      pce_pkg::RATE_2_3: begin
        res_cnt = 3'd3;
      end
      pce_pkg::RATE_3_4: begin
        res_cnt = 3'd2;
      end
      pce_pkg::RATE_5_6: begin
        res[2]  = {gbe[4][0], gbe[3][1]};
        res_cnt = 3'd3;
      end
      pce_pkg::RATE_7_8: begin
        res[1]  = {gbe[2][1], gbe[1][1]};
        res[2]  = {gbe[4][0], gbe[3][1]};
        res_cnt = 3'd4;
      end
      default: begin
        res[0]  = d;
        res_cnt = 3'd1;
      end
    endcase
  end

  // a finishing dibit waits until the result stage drains
  assign pop_ok    = out_pop && (pend_cnt_r != 3'd0);
  assign pend_free = (pend_cnt_r == 3'd0) || ((pend_cnt_r == 3'd1) && out_pop);
  assign step      = busy_r && (!complete || pend_free);
  assign q_pop     = q_valid && (!busy_r || (step && (idx_r == 3'd7)));

  // result stage next state
  always_comb begin
    pend_nxt      = pend_r;
    pend_cnt_nxt  = pend_cnt_r;
    pend_last_nxt = pend_last_r;
    if (step && complete) begin
      pend_nxt      = res;
      pend_cnt_nxt  = res_cnt;
      pend_last_nxt = group_last;
    end else if (pop_ok) begin
      for (int k = 0; k < 3; k++) begin
        pend_nxt[k] = pend_r[k+1];
      end
      pend_cnt_nxt = pend_cnt_r - 3'd1;
    end
  end

  assign out_empty       = (pend_cnt_r == 3'd0);
  assign out_dibit       = pend_r[0];
  assign out_last_of_run = pend_last_r && (pend_cnt_r == 3'd1);
  assign status.busy     = busy_r;
  assign status.pend_cnt = pend_cnt_r;

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_entry;
    end
    if (step && punct) begin
      gb_r[fill0] <= d;
    end
    pend_r <= pend_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      fill_r      <= '0;
      pend_cnt_r  <= '0;
      pend_last_r <= 1'b0;
    end else begin
      pend_cnt_r  <= pend_cnt_nxt;
      pend_last_r <= pend_last_nxt;
      if (step && punct) begin
        fill_r <= complete ? 3'd0 : fill1;
      end
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (step && (idx_r == 3'd7)) begin
        busy_r <= 1'b0;
      end else if (step) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: test/pce_checker.sv
// ----------------------------------------------------------------------------
// pce_checker
// watches the byte, rate and dibit channels of the punctured k=7 encoder,
// predicts every punctured dibit and compares each result transfer with it
// ----------------------------------------------------------------------------
module pce_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_code_rate,
  input  logic       in_push,
  input  logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       out_pop,
  input  logic       out_empty,
  input  logic [1:0] out_dibit,
  input  logic       out_last_of_run,
  output int         fail_count,
  output int         pending
);

  // one expected result transfer
  typedef struct packed {
    logic [1:0] dibit;
    logic       last;
  } dibit_exp_t;

  // predictor state
  logic [2:0] cur_rate = pce_pkg::RATE_1_2;
  logic [6:0] enc_sr   = '0;
  logic [1:0] grp_buf [0:6];
  logic [2:0] grp_fill = '0;

  dibit_exp_t dibit_q [$];
  int         mism_cnt  = 0;
  int         depth_cnt = 0;

  assign fail_count = mism_cnt;
  assign pending    = depth_cnt;

  initial begin
    for (int i = 0; i < 7; i++) grp_buf[i] = 2'b00;
  end

  // one line per mismatch
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mism_cnt++;
  endtask

  // encode one byte msb first and puncture the dibits into expected transfers
  task automatic predict_byte(input logic [7:0] data);
    dibit_exp_t run_q [$];
    logic [1:0] d;
    logic [2:0] rate;
    logic [2:0] gsize;
    rate = (cur_rate <= pce_pkg::RATE_7_8) ? cur_rate : pce_pkg::RATE_1_2;
    case (rate)
      pce_pkg::RATE_2_3: gsize = 3'd4;
      pce_pkg::RATE_3_4: gsize = 3'd3;
      pce_pkg::RATE_5_6: gsize = 3'd5;
      pce_pkg::RATE_7_8: gsize = 3'd7;
      default:           gsize = 3'd1;
    endcase
    for (int b = 7; b >= 0; b--) begin
      enc_sr = {data[b], enc_sr[6:1]};
      d = {^(enc_sr & pce_pkg::TAPS_Y), ^(enc_sr & pce_pkg::TAPS_X)};
      // rate 1/2 bypasses the group buffer entirely
      if (rate == pce_pkg::RATE_1_2) begin
        run_q.push_back('{dibit: d, last: 1'b0});
        continue;
      end
      // a fill left over from a larger group restarts the group
      if (grp_fill >= gsize) grp_fill = 3'd0;
      grp_buf[grp_fill] = d;
      grp_fill = grp_fill + 3'd1;
      if (grp_fill != gsize) continue;
      grp_fill = 3'd0;
      run_q.push_back('{dibit: grp_buf[0], last: 1'b0});
      case (rate)
        pce_pkg::RATE_2_3: begin
          run_q.push_back('{dibit: {grp_buf[2][0], grp_buf[1][1]}, last: 1'b0});
          run_q.push_back('{dibit: {grp_buf[3][1], grp_buf[2][1]}, last: 1'b0});
        end
        pce_pkg::RATE_3_4: begin
          run_q.push_back('{dibit: {grp_buf[2][0], grp_buf[1][1]}, last: 1'b0});
        end
        pce_pkg::RATE_5_6: begin
          run_q.push_back('{dibit: {grp_buf[2][0], grp_buf[1][1]}, last: 1'b0});
          run_q.push_back('{dibit: {grp_buf[4][0], grp_buf[3][1]}, last: 1'b0});
        end
        default: begin
          run_q.push_back('{dibit: {grp_buf[2][1], grp_buf[1][1]}, last: 1'b0});
          run_q.push_back('{dibit: {grp_buf[4][0], grp_buf[3][1]}, last: 1'b0});
          run_q.push_back('{dibit: {grp_buf[6][0], grp_buf[5][1]}, last: 1'b0});
        end
      endcase
    end
    // flag the final dibit of this byte
    if (run_q.size() != 0) run_q[run_q.size() - 1].last = 1'b1;
    foreach (run_q[i]) dibit_q.push_back(run_q[i]);
  endtask

  // sample all channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      cur_rate = pce_pkg::RATE_1_2;
      enc_sr   = '0;
      grp_fill = '0;
      dibit_q.delete();
    end else begin
      // result transfer against the oldest expectation
      if (out_pop && !out_empty) begin
        if (dibit_q.size() == 0) begin
          report_mismatch("unexpected result, dibit", out_dibit, -1);
        end else begin
          if (out_dibit !== dibit_q[0].dibit)
            report_mismatch("dibit", out_dibit, dibit_q[0].dibit);
          if (out_last_of_run !== dibit_q[0].last)
            report_mismatch("last_of_run", out_last_of_run, dibit_q[0].last);
          void'(dibit_q.pop_front());
        end
      end
      if (cfg_we) cur_rate = cfg_code_rate;
      // byte transfer
      if (in_push && !in_full) predict_byte(in_data_byte);
    end
    depth_cnt = dibit_q.size();
  end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives bytes and rate writes into the punctured k=7 encoder under bursty
// sending and a stalling receiver; the checker judges every dibit
// ----------------------------------------------------------------------------
module testbench;

  // rate codes the design does not name, all treated as rate 1/2
  localparam logic [2:0] RATE_SPARE_5 = 3'd5;
  localparam logic [2:0] RATE_SPARE_6 = 3'd6;
  localparam logic [2:0] RATE_SPARE_7 = 3'd7;

  localparam int PHASE_ITEMS = 43;
  localparam int NUM_PHASES  = 10;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       cfg_we        = 1'b0;
  logic [2:0] cfg_code_rate = pce_pkg::RATE_1_2;
  logic       in_push       = 1'b0;
  logic [7:0] in_data_byte  = 8'h00;
  logic       in_full;
  logic       out_empty;
  logic       out_pop       = 1'b0;
  logic [1:0] out_dibit;
  logic       out_last_of_run;
  int         fail_count;
  int         pending;

  // receiver pattern state
  int         mode_left  = 0;
  int         pop_mode   = 0;
  int         mask_pos   = 0;
  int         stall_left = 0;
  logic [7:0] stall_mask = 8'hFF;

  punctured_conv_encoder_k7 i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_code_rate   (cfg_code_rate),
    .in_push         (in_push),
    .in_data_byte    (in_data_byte),
    .in_full         (in_full),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_dibit       (out_dibit),
    .out_last_of_run (out_last_of_run)
  );

  pce_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_code_rate   (cfg_code_rate),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_data_byte    (in_data_byte),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_dibit       (out_dibit),
    .out_last_of_run (out_last_of_run),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: switches between free flow, coin flips, a rotating mask and long stalls
  always @(negedge clk) begin
    if (mode_left == 0) begin
      pop_mode   = $urandom_range(0, 3);
      stall_mask = 8'($urandom) | 8'h01;
      mode_left  = $urandom_range(16, 96);
    end else begin
      mode_left = mode_left - 1;
    end
    case (pop_mode)
      0: out_pop <= 1'b1;
      1: out_pop <= 1'($urandom_range(0, 1));
      2: begin
        out_pop <= stall_mask[mask_pos];
        mask_pos = (mask_pos + 1) % 8;
      end
      default: begin
        out_pop <= (stall_left == 0);
        if (stall_left == 0) stall_left = $urandom_range(5, 20);
        else stall_left = stall_left - 1;
      end
    endcase
  end

  // one byte transfer, entered and left at a falling edge
  task automatic send_byte(input logic [7:0] data);
    in_push      <= 1'b1;
    in_data_byte <= data;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender until every expected dibit is out, then let the walker finish
  task automatic wait_drained();
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  // rate write while the block is idle
  task automatic set_rate(input logic [2:0] rate);
    wait_drained();
    cfg_we        <= 1'b1;
    cfg_code_rate <= rate;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [2:0] rate;
    logic [7:0] data;
    int         sent;
    int         burst;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset rate, field extremes
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    // rate 7/8, leaves a group three deep
    set_rate(pce_pkg::RATE_7_8);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hA5);
    // fill at or above the new group size restarts the group
    set_rate(pce_pkg::RATE_3_4);
    send_byte(8'h3C);
    // rate 1/2 in the middle of a group leaves the group alone
    set_rate(pce_pkg::RATE_1_2);
    send_byte(8'h55);
    set_rate(pce_pkg::RATE_3_4);
    send_byte(8'hAA);
    set_rate(pce_pkg::RATE_2_3);
    send_byte(8'h0F);
    send_byte(8'hF0);
    set_rate(pce_pkg::RATE_5_6);
    send_byte(8'h81);
    send_byte(8'h7E);
    // unused rate codes
    set_rate(RATE_SPARE_5);
    send_byte(8'hC3);
    set_rate(RATE_SPARE_7);
    send_byte(8'h3C);
    set_rate(RATE_SPARE_6);
    send_byte(8'h99);

    // random phases, each at its own rate, bytes in bursts
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) rate = pce_pkg::RATE_7_8;
      else if (ph == 1) rate = pce_pkg::RATE_1_2;
      else if ($urandom_range(0, 4) == 0) rate = 3'($urandom_range(5, 7));
      else rate = 3'($urandom_range(0, 4));
      set_rate(rate);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 16);
        if ($urandom_range(0, 9) == 0) burst = 40;
        for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          data = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 9) == 0) data = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          send_byte(data);
          sent++;
        end
        in_push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end

    // drain and verdict
    wait_drained();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/pce_pkg.sv
sv/pce_front.sv
sv/pce_queue.sv
sv/pce_back.sv
sv/punctured_conv_encoder_k7.sv
test/pce_checker.sv
test/testbench.sv
